FILE: rtl/first_fit_pool_allocator_unit_defines.svh
// Assertion macros for the first-fit pool allocator.
// Used by the top level; expects clk and rst in scope.
`ifndef FIRST_FIT_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_POOL_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define FFPA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffpa check failed");

// Next-cycle implication, disabled during reset
`define FFPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffpa check failed");

`endif

FILE: rtl/ffpa_pkg.sv
// Shared types and constants for the first-fit pool allocator.
// No dependencies.
`default_nettype none

package ffpa_pkg;

  localparam int HDR_BYTES = 16;
  localparam int WORD_W    = 32;
  localparam int FREE_W    = 13;

  // Header word selector; byte distance below the payload is 16 - 4*code
  typedef enum logic [1:0] {
    BK_PREV = 2'd0,
    BK_NEXT = 2'd1,
    BK_USED = 2'd2,
    BK_SIZE = 2'd3
  } back_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOFREE  = 3'd2,
    ST_NOFIT   = 3'd3,
    ST_BADFREE = 3'd4
  } status_t;

  // One header word access
  typedef struct packed {
    logic               en;
    logic               we;
    logic [WORD_W-1:0]  addr;
    back_t              back;
    logic [WORD_W-1:0]  wdata;
  } mem_req_t;

endpackage

`default_nettype wire

FILE: rtl/ffpa_hdr_mem.sv
// Byte pool seen as header words: four byte banks allow one unaligned
// 32-bit read or write per cycle. Depends on ffpa_pkg.
`default_nettype none

module ffpa_hdr_mem #(
  parameter int POOL_BYTES = 4096
) (
  input  wire                       clk,
  input  wire ffpa_pkg::mem_req_t   req,
  output logic [ffpa_pkg::WORD_W-1:0] rdata
);
  import ffpa_pkg::*;

  localparam int AW         = $clog2(POOL_BYTES);
  localparam int BAW        = AW - 2;
  localparam int BANK_DEPTH = (POOL_BYTES + 3) / 4;

  logic          in_range;
  logic [AW:0]   pfull;
  logic [AW-1:0] p;
  logic [AW:0]   back_off;
  logic [1:0]    p_lo;
  logic          rd_range;
  logic [7:0]    q [4];

  // Map the header word to its first byte
  assign in_range = (req.addr >= WORD_W'(HDR_BYTES)) && (req.addr <= WORD_W'(POOL_BYTES));
  assign back_off = (AW+1)'(HDR_BYTES) - (AW+1)'({req.back, 2'b00});
  assign pfull    = req.addr[AW:0] - back_off;
  assign p        = pfull[AW-1:0];

  genvar k;
  generate
    for (k = 0; k < 4; k++) begin : g_bank
      logic [7:0]    mem [0:BANK_DEPTH-1];
      logic [1:0]    lane;
      logic [AW-1:0] baddr_full;
      logic [BAW-1:0] baddr;
      logic [7:0]    wbyte;

      assign lane       = 2'(k) - p[1:0];
      assign baddr_full = p + AW'(lane);
      assign baddr      = baddr_full[AW-1:2];
      assign wbyte      = 8'(req.wdata >> {lane, 3'b000});

      // Write and read one byte of the word
      always_ff @(posedge clk) begin
        if (req.en && req.we && in_range) begin
          mem[baddr] <= wbyte;
        end
        q[k] <= mem[baddr];
      end
    end
  endgenerate

  // Hold lane alignment and range for the returning data
  always_ff @(posedge clk) begin
    p_lo     <= p[1:0];
    rd_range <= in_range;
  end

  // Reassemble the word, out-of-range reads as zero
  always_comb begin
    rdata = '0;
    for (int i = 0; i < 4; i++) begin
      rdata[8*i +: 8] = q[2'(p_lo + 2'(i))];
    end
    if (!rd_range) begin
      rdata = '0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/first_fit_pool_allocator_unit.sv
// First-fit pool allocator with neighbor coalescing.
// Input channel: action, length, reserve, offset; accepted when in_valid is
// high and in_stall low. Output channel: region_offset, status, free_bytes;
// taken when out_valid is high and out_stall low. One result per transaction.
// Work is done by a sequencer over a single header-word port (one 32-bit read
// or write per cycle, read data in the next cycle), so one item is in flight.
// Rejected requests go straight to the result. An allocate reads the used,
// size and next words of each block on the chain and takes the first free
// block that fits, split when it exceeds the request by 2*HDR_BYTES or more.
// A free checks the header, reads the neighbors' used words, then releases
// the block and merges it with any free neighbor. The chain walk (up to
// POOL_BYTES/16+1 blocks) sets the worst-case time of an allocate. After
// reset, with in_stall high, the block writes the four first-header words.
// A finished result sits in an output register; the block takes the next
// transaction while it waits, and holds the following result until the receiver drops out_stall.
// Depends on ffpa_pkg, ffpa_hdr_mem and the assertion macro header.
`default_nettype none
`include "first_fit_pool_allocator_unit_defines.svh"

module first_fit_pool_allocator_unit #(
  parameter int POOL_BYTES = 4096
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         action,
  input  wire  [12:0] length,
  input  wire  [12:0] reserve,
  input  wire  [11:0] offset,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [11:0] region_offset,
  output logic [2:0]  status,
  output logic [11:0] free_bytes
);
  import ffpa_pkg::*;

  localparam int LIMIT = POOL_BYTES / HDR_BYTES + 1;
  localparam int SW    = $clog2(LIMIT + 1);

  typedef enum logic [5:0] {
    S_INIT, S_IDLE,
    S_A_USED, S_A_SIZE, S_A_NEXT, S_A_EVAL, S_SPLIT,
    S_F_USED, S_F_PREV, S_F_NEXT, S_F_SIZE, S_F_CHK, S_F_UN, S_F_DEC,
    S_R_W, S_R_RD, S_R_ADD,
    S_B_NN, S_B_W1, S_B_R1, S_B_R2, S_B_W2, S_B_W3, S_B_W4,
    S_C_RP, S_C_W1, S_C_RN, S_C_W2, S_C_W3,
    S_D_NN, S_D_RP, S_D_RS, S_D_W1, S_D_W2, S_D_W3,
    S_FIN
  } state_t;

  state_t            state;
  logic [2:0]        idx;
  logic [12:0]       len;
  logic [WORD_W-1:0] cur, pv, nx, used_w, size_w, up_w, t0, t1;
  logic [SW-1:0]     steps;
  logic [FREE_W-1:0] fc;
  logic              big;
  logic              is_alloc;
  status_t           st;
  mem_req_t          req;
  logic [WORD_W-1:0] rdata;

  logic signed [14:0] headroom;
  logic               pv0, nx0, up0, up1, un0, un1;

  assign headroom = $signed({2'b00, fc}) - $signed({2'b00, reserve});
  assign pv0 = (pv == '0);
  assign nx0 = (nx == '0);
  assign up0 = (up_w == '0);
  assign up1 = (up_w == WORD_W'(1));
  assign un0 = (rdata == '0);
  assign un1 = (rdata == WORD_W'(1));

  assign in_stall = (state != S_IDLE);

  ffpa_hdr_mem #(.POOL_BYTES(POOL_BYTES)) u_mem (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // Drive the header-word port from the sequencer state
  always_comb begin
    req = '{en: 1'b0, we: 1'b0, addr: '0, back: BK_PREV, wdata: '0};
    unique case (state)
      S_INIT: req = '{1'b1, 1'b1, WORD_W'(HDR_BYTES), back_t'(idx[1:0]),
                      (idx[1:0] == BK_SIZE) ? WORD_W'(POOL_BYTES - HDR_BYTES) : '0};
      S_A_USED: req = '{1'b1, 1'b0, cur, BK_USED, '0};
      S_A_SIZE: req = '{1'b1, 1'b0, cur, BK_SIZE, '0};
      S_A_NEXT: req = '{1'b1, 1'b0, cur, BK_NEXT, '0};
      S_SPLIT: begin
        unique case (idx)
          3'd0:    req = '{1'b1, 1'b1, cur, BK_NEXT, t0};
          3'd1:    req = '{1'b1, 1'b1, cur, BK_USED, WORD_W'(1)};
          3'd2:    req = '{1'b1, 1'b1, cur, BK_SIZE, WORD_W'(len)};
          3'd3:    req = '{1'b1, 1'b1, t0, BK_NEXT, nx};
          3'd4:    req = '{1'b1, 1'b1, t0, BK_PREV, cur};
          3'd5:    req = '{1'b1, 1'b1, t0, BK_USED, '0};
          default: req = '{1'b1, 1'b1, t0, BK_SIZE,
                           size_w - WORD_W'(len) - WORD_W'(HDR_BYTES)};
        endcase
      end
      S_F_USED: req = '{1'b1, 1'b0, cur, BK_USED, '0};
      S_F_PREV: req = '{1'b1, 1'b0, cur, BK_PREV, '0};
      S_F_NEXT: req = '{1'b1, 1'b0, cur, BK_NEXT, '0};
      S_F_SIZE: req = '{1'b1, 1'b0, cur, BK_SIZE, '0};
      S_F_CHK:  req = '{1'b1, 1'b0, pv, BK_USED, '0};
      S_F_UN:   req = '{1'b1, 1'b0, nx, BK_USED, '0};
      S_R_W:    req = '{1'b1, 1'b1, cur, BK_USED, '0};
      S_R_RD:   req = '{1'b1, 1'b0, cur, BK_SIZE, '0};
      S_B_NN:   req = '{1'b1, 1'b0, nx, BK_NEXT, '0};
      S_B_W1:   req = '{1'b1, 1'b1, cur, BK_USED, '0};
      S_B_R1:   req = '{1'b1, 1'b0, cur, BK_SIZE, '0};
      S_B_R2:   req = '{1'b1, 1'b0, nx, BK_SIZE, '0};
      S_B_W2:   req = '{1'b1, 1'b1, cur, BK_SIZE, t1 + rdata + WORD_W'(HDR_BYTES)};
      S_B_W3:   req = '{1'b1, 1'b1, cur, BK_NEXT, t0};
      S_B_W4:   req = '{1'b1, 1'b1, t0, BK_PREV, cur};
      S_C_RP:   req = '{1'b1, 1'b0, pv, BK_SIZE, '0};
      S_C_W1:   req = '{1'b1, 1'b1, pv, BK_SIZE, rdata + size_w + WORD_W'(HDR_BYTES)};
      S_C_RN:   req = '{1'b1, 1'b0, cur, BK_NEXT, '0};
      S_C_W2:   req = '{1'b1, 1'b1, pv, BK_NEXT, rdata};
      S_C_W3:   req = '{1'b1, 1'b1, nx, BK_PREV, pv};
      S_D_NN:   req = '{1'b1, 1'b0, nx, BK_NEXT, '0};
      S_D_RP:   req = '{1'b1, 1'b0, pv, BK_SIZE, '0};
      S_D_RS:   req = '{1'b1, 1'b0, nx, BK_SIZE, '0};
      S_D_W1:   req = '{1'b1, 1'b1, pv, BK_SIZE, t1 + rdata + WORD_W'(HDR_BYTES)};
      S_D_W2:   req = '{1'b1, 1'b1, pv, BK_NEXT, t0};
      S_D_W3:   req = '{1'b1, 1'b1, t0, BK_PREV, pv};
      default:  req = '{en: 1'b0, we: 1'b0, addr: '0, back: BK_PREV, wdata: '0};
    endcase
  end

  // Sequencer, free count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      idx       <= '0;
      fc        <= FREE_W'(POOL_BYTES - HDR_BYTES);
      out_valid <= 1'b0;
    end else begin
      // Drop a result once the receiver takes it
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          idx <= idx + 3'd1;
          if (idx == 3'd3) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            len      <= length;
            is_alloc <= !action;
            st       <= ST_OK;
            if (!action) begin
              cur   <= WORD_W'(HDR_BYTES);
              steps <= '0;
              priority if (length == '0) begin
                st    <= ST_ZERO;
                state <= S_FIN;
              end else if ((length > fc) || ($signed({2'b00, length}) > headroom)) begin
                st    <= ST_NOFREE;
                state <= S_FIN;
              end else begin
                state <= S_A_USED;
              end
            end else begin
              cur <= WORD_W'(offset);
              if ((offset < 12'(HDR_BYTES)) ||
                  ({20'b0, offset} >= WORD_W'(POOL_BYTES))) begin
                st    <= ST_BADFREE;
                state <= S_FIN;
              end else begin
                state <= S_F_USED;
              end
            end
          end
        end
        S_A_USED: state <= S_A_SIZE;
        S_A_SIZE: begin
          used_w <= rdata;
          state  <= S_A_NEXT;
        end
        S_A_NEXT: begin
          size_w <= rdata;
          state  <= S_A_EVAL;
        end
        S_A_EVAL: begin
          priority if ((used_w == '0) && (size_w >= WORD_W'(len))) begin
            nx    <= rdata;
            t0    <= cur + WORD_W'(len) + WORD_W'(HDR_BYTES);
            state <= S_SPLIT;
            if (size_w >= WORD_W'(len) + WORD_W'(2 * HDR_BYTES)) begin
              big <= 1'b1;
              idx <= 3'd0;
              fc  <= fc - (len + FREE_W'(HDR_BYTES));
            end else begin
              big <= 1'b0;
              idx <= 3'd1;
              fc  <= fc - size_w[FREE_W-1:0];
            end
          end else if (rdata == '0) begin
            st    <= ST_NOFIT;
            state <= S_FIN;
          end else begin
            cur   <= rdata;
            steps <= steps + SW'(1);
            if (steps == SW'(LIMIT - 1)) begin
              st    <= ST_NOFIT;
              state <= S_FIN;
            end else begin
              state <= S_A_USED;
            end
          end
        end
        S_SPLIT: begin
          idx <= idx + 3'd1;
          if ((!big && idx == 3'd1) || idx == 3'd6) begin
            state <= S_FIN;
          end
        end
        S_F_USED: state <= S_F_PREV;
        S_F_PREV: begin
          used_w <= rdata;
          state  <= S_F_NEXT;
        end
        S_F_NEXT: begin
          pv    <= rdata;
          state <= S_F_SIZE;
        end
        S_F_SIZE: begin
          nx    <= rdata;
          state <= S_F_CHK;
        end
        S_F_CHK: begin
          size_w <= rdata;
          if ((used_w != WORD_W'(1)) || (pv >= cur) || (nx >= WORD_W'(POOL_BYTES)) ||
              (rdata >= WORD_W'(POOL_BYTES)) || (rdata == '0)) begin
            st    <= ST_BADFREE;
            state <= S_FIN;
          end else begin
            state <= S_F_UN;
          end
        end
        S_F_UN: begin
          up_w  <= rdata;
          state <= S_F_DEC;
        end
        // Pick the merge case from the neighbors' used words
        S_F_DEC: begin
          priority if (pv0) begin
            priority if (nx0 || un1) begin
              state <= S_R_W;
            end else if (un0) begin
              fc    <= fc + size_w[FREE_W-1:0] + FREE_W'(HDR_BYTES);
              state <= S_B_NN;
            end else begin
              state <= S_FIN;
            end
          end else if (nx0) begin
            priority if (up1) begin
              state <= S_R_W;
            end else if (up0) begin
              fc    <= fc + size_w[FREE_W-1:0] + FREE_W'(HDR_BYTES);
              state <= S_C_RP;
            end else begin
              state <= S_FIN;
            end
          end else begin
            priority if (up1 && un1) begin
              state <= S_R_W;
            end else if (up1 && un0) begin
              fc    <= fc + size_w[FREE_W-1:0] + FREE_W'(HDR_BYTES);
              state <= S_B_NN;
            end else if (up0 && un1) begin
              fc    <= fc + size_w[FREE_W-1:0] + FREE_W'(HDR_BYTES);
              state <= S_C_RP;
            end else if (up0 && un0) begin
              fc    <= fc + size_w[FREE_W-1:0] + FREE_W'(2 * HDR_BYTES);
              state <= S_D_NN;
            end else begin
              state <= S_FIN;
            end
          end
        end
        // Release only
        S_R_W:  state <= S_R_RD;
        S_R_RD: state <= S_R_ADD;
        S_R_ADD: begin
          fc    <= fc + rdata[FREE_W-1:0];
          state <= S_FIN;
        end
        // Absorb the following block
        S_B_NN: state <= S_B_W1;
        S_B_W1: begin
          t0    <= rdata;
          state <= S_B_R1;
        end
        S_B_R1: state <= S_B_R2;
        S_B_R2: begin
          t1    <= rdata;
          state <= S_B_W2;
        end
        S_B_W2: state <= S_B_W3;
        S_B_W3: state <= (t0 != '0) ? S_B_W4 : S_FIN;
        S_B_W4: state <= S_FIN;
        // Fold into the previous block
        S_C_RP: state <= S_C_W1;
        S_C_W1: state <= S_C_RN;
        S_C_RN: state <= S_C_W2;
        S_C_W2: state <= nx0 ? S_FIN : S_C_W3;
        S_C_W3: state <= S_FIN;
        // Fold this and the following block into the previous one
        S_D_NN: state <= S_D_RP;
        S_D_RP: begin
          t0    <= rdata;
          state <= S_D_RS;
        end
        S_D_RS: begin
          t1    <= rdata + size_w + WORD_W'(HDR_BYTES);
          state <= S_D_W1;
        end
        S_D_W1: state <= S_D_W2;
        S_D_W2: state <= (t0 != '0) ? S_D_W3 : S_FIN;
        S_D_W3: state <= S_FIN;
        // Load the result once the output register is free
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            region_offset <= (is_alloc && st == ST_OK) ? cur[11:0] : 12'd0;
            status        <= st;
            free_bytes    <= fc[11:0];
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FFPA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `FFPA_ASSERT_NOW(a_fail_no_region, out_valid && (status != ST_OK), region_offset == 12'd0)
  `FFPA_ASSERT_NOW(a_split_fits, state == S_SPLIT, size_w >= WORD_W'(len))

endmodule

`default_nettype wire

FILE: dv/tb_first_fit_pool_allocator_unit.sv
// Self-checking testbench for the first-fit pool allocator unit.
// Directed table then random allocate/free traffic, checked against an
// in-bench pool model. Depends on ffpa_pkg and the unit RTL.
`timescale 1ns / 100ps

module tb_first_fit_pool_allocator_unit;
  import ffpa_pkg::*;

  localparam int unsigned POOL   = 4096;
  localparam int unsigned HB     = 16;
  localparam int unsigned B_PREV = 16;
  localparam int unsigned B_NEXT = 12;
  localparam int unsigned B_USED = 8;
  localparam int unsigned B_SIZE = 4;
  localparam int unsigned WALK_MAX = POOL / HB + 1;
  localparam int N_RANDOM = 1350;
  localparam int WATCHDOG = 20000;
  localparam bit ACT_ALLOC = 1'b0;
  localparam bit ACT_FREE  = 1'b1;

  typedef struct packed {
    logic [11:0] region;
    status_t     st;
    logic [11:0] fbytes;
  } alloc_result_t;

  typedef struct packed {
    logic        act;
    logic [12:0] len;
    logic [12:0] res;
    logic [11:0] off;
    logic        typed;
    logic [11:0] e_region;
    status_t     e_st;
    logic [11:0] e_free;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = 1'b0;
  logic [12:0] length = '0;
  logic [12:0] reserve = '0;
  logic [11:0] offset = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [11:0] region_offset;
  logic [2:0] status;
  logic [11:0] free_bytes;

  first_fit_pool_allocator_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .length(length), .reserve(reserve), .offset(offset),
    .out_valid(out_valid), .out_stall(out_stall),
    .region_offset(region_offset), .status(status), .free_bytes(free_bytes)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pool shadow
  logic [7:0]  pool_mem [POOL];
  bit          pool_seen [POOL];
  logic [12:0] free_cnt;

  alloc_result_t pending_q[$];
  int unsigned   live_q[$];
  int unsigned   dead_q[$];
  int errors = 0;
  bit quiet = 1'b0;
  bit stim_done = 1'b0;

  function automatic logic [31:0] hdr_read(int unsigned a, int unsigned back);
    int unsigned p;
    if (a < HB || a > POOL) return '0;
    p = a - back;
    return {pool_mem[p+3], pool_mem[p+2], pool_mem[p+1], pool_mem[p]};
  endfunction

  function automatic void hdr_write(int unsigned a, int unsigned back, logic [31:0] v);
    int unsigned p;
    if (a < HB || a > POOL) return;
    p = a - back;
    for (int i = 0; i < 4; i++) begin
      pool_mem[p+i] = v[8*i +: 8];
      pool_seen[p+i] = 1'b1;
    end
  endfunction

  function automatic void add_free(logic [31:0] v);
    free_cnt = free_cnt + v[12:0];
  endfunction

  function automatic void absorb_next(int unsigned cur, int unsigned nx);
    logic [31:0] nn;
    nn = hdr_read(nx, B_NEXT);
    add_free(hdr_read(cur, B_SIZE) + HB);
    hdr_write(cur, B_USED, 0);
    hdr_write(cur, B_SIZE, hdr_read(cur, B_SIZE) + hdr_read(nx, B_SIZE) + HB);
    hdr_write(cur, B_NEXT, nn);
    if (nn != 0) hdr_write(nn, B_PREV, cur);
  endfunction

  function automatic void release_only(int unsigned cur);
    hdr_write(cur, B_USED, 0);
    add_free(hdr_read(cur, B_SIZE));
  endfunction

  function automatic void fold_into_prev(int unsigned pv, int unsigned cur);
    add_free(hdr_read(cur, B_SIZE) + HB);
    hdr_write(pv, B_SIZE, hdr_read(pv, B_SIZE) + hdr_read(cur, B_SIZE) + HB);
    hdr_write(pv, B_NEXT, hdr_read(cur, B_NEXT));
  endfunction

  function automatic void coalesce(int unsigned pv, int unsigned cur, int unsigned nx);
    logic [31:0] up, un, nn;
    up = hdr_read(pv, B_USED);
    un = hdr_read(nx, B_USED);
    if (pv == 0) begin
      if (nx == 0 || un == 1) release_only(cur);
      else if (un == 0) absorb_next(cur, nx);
    end else if (nx == 0) begin
      if (up == 1) release_only(cur);
      else if (up == 0) fold_into_prev(pv, cur);
    end else if (up == 1 && un == 1) begin
      release_only(cur);
    end else if (up == 1 && un == 0) begin
      absorb_next(cur, nx);
    end else if (up == 0 && un == 1) begin
      fold_into_prev(pv, cur);
      hdr_write(nx, B_PREV, pv);
    end else if (up == 0 && un == 0) begin
      nn = hdr_read(nx, B_NEXT);
      add_free(hdr_read(cur, B_SIZE) + 2 * HB);
      hdr_write(pv, B_SIZE, hdr_read(pv, B_SIZE) + hdr_read(cur, B_SIZE) + HB +
                            hdr_read(nx, B_SIZE) + HB);
      hdr_write(pv, B_NEXT, nn);
      if (nn != 0) hdr_write(nn, B_PREV, pv);
    end
  endfunction

  function automatic void carve_block(int unsigned a, int unsigned len);
    logic [31:0] sz, onext;
    int unsigned nb;
    sz = hdr_read(a, B_SIZE);
    if (longint'(sz) >= longint'(len) + 2 * HB) begin
      onext = hdr_read(a, B_NEXT);
      nb = a + len + HB;
      free_cnt = free_cnt - 13'(len + HB);
      hdr_write(a, B_NEXT, nb);
      hdr_write(a, B_USED, 1);
      hdr_write(a, B_SIZE, len);
      hdr_write(nb, B_NEXT, onext);
      hdr_write(nb, B_PREV, a);
      hdr_write(nb, B_USED, 0);
      hdr_write(nb, B_SIZE, sz - len - HB);
    end else begin
      free_cnt = free_cnt - sz[12:0];
      hdr_write(a, B_USED, 1);
    end
  endfunction

  // Compute the result of one transaction and update the shadow pool
  function automatic alloc_result_t predict_alloc(logic act, logic [12:0] len,
                                                  logic [12:0] res, logic [11:0] off);
    alloc_result_t r;
    int unsigned cur, steps, o;
    bit found;
    r.region = '0;
    r.st = ST_OK;
    if (act == ACT_ALLOC) begin
      if (len == 0) r.st = ST_ZERO;
      else if (len > free_cnt) r.st = ST_NOFREE;
      else if (int'(len) > int'(free_cnt) - int'(res)) r.st = ST_NOFREE;
      else begin
        cur = HB;
        steps = 0;
        found = 1'b0;
        while (steps < WALK_MAX && !found) begin
          if (hdr_read(cur, B_USED) == 0 && hdr_read(cur, B_SIZE) >= len) begin
            carve_block(cur, len);
            r.region = cur[11:0];
            found = 1'b1;
          end else if (hdr_read(cur, B_NEXT) == 0) begin
            steps = WALK_MAX;
          end else begin
            cur = hdr_read(cur, B_NEXT);
            steps++;
          end
        end
        if (!found) r.st = ST_NOFIT;
      end
    end else begin
      o = 32'(off);
      if (o < HB || o >= POOL) r.st = ST_BADFREE;
      else if (hdr_read(o, B_USED) != 1 || hdr_read(o, B_PREV) >= o ||
               hdr_read(o, B_NEXT) >= POOL || hdr_read(o, B_SIZE) >= POOL ||
               hdr_read(o, B_SIZE) == 0)
        r.st = ST_BADFREE;
      else coalesce(hdr_read(o, B_PREV), o, hdr_read(o, B_NEXT));
    end
    r.fbytes = free_cnt[11:0];
    return r;
  endfunction

  // True when every header byte below the offset has been written
  function automatic bit header_known(int unsigned o);
    if (o < HB) return 1'b1;
    for (int unsigned i = o - HB; i < o; i++)
      if (!pool_seen[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void track_region(logic act, logic [11:0] off, alloc_result_t r);
    if (r.st != ST_OK) return;
    if (act == ACT_ALLOC) live_q.push_back(32'(r.region));
    else
      foreach (live_q[i])
        if (live_q[i] == 32'(off)) begin
          dead_q.push_back(live_q[i]);
          live_q.delete(i);
          break;
        end
  endfunction

  // Offer one transaction, waiting out random idle cycles first
  task automatic offer(logic act, logic [12:0] len, logic [12:0] res, logic [11:0] off,
                       output alloc_result_t got);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 11) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    action = act;
    length = len;
    reserve = res;
    offset = off;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = predict_alloc(act, len, res, off);
    track_region(act, off, got);
  endtask

  // Receiver stall
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= !quiet && ($urandom_range(99) < 11);
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    alloc_result_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: reg=%0d st=%0d free=%0d",
                                   region_offset, status, free_bytes);
      end else begin
        w = pending_q.pop_front();
        if (region_offset !== w.region || status !== w.st || free_bytes !== w.fbytes) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp reg=%0d st=%0d free=%0d got reg=%0d st=%0d free=%0d",
                     w.region, w.st, w.fbytes, region_offset, status, free_bytes);
        end
      end
    end
  end

  // Stop on a long run with no transaction on either channel
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("tb_first_fit_pool_allocator_unit NOT OK");
      $finish;
    end
  end

  dir_row_t rows [16];

  initial begin
    alloc_result_t got;
    logic act;
    logic [12:0] len, res;
    logic [11:0] off;
    int unsigned k;

    rows = '{
      '{ACT_ALLOC, 13'd0,    13'd0,    12'd0,   1'b1, 12'd0,  ST_ZERO,    12'd4080},
      '{ACT_ALLOC, 13'd8191, 13'd0,    12'd0,   1'b1, 12'd0,  ST_NOFREE,  12'd4080},
      '{ACT_ALLOC, 13'd4080, 13'd1,    12'd0,   1'b1, 12'd0,  ST_NOFREE,  12'd4080},
      '{ACT_ALLOC, 13'd16,   13'd8191, 12'd0,   1'b1, 12'd0,  ST_NOFREE,  12'd4080},
      '{ACT_FREE,  13'd0,    13'd0,    12'd0,   1'b1, 12'd0,  ST_BADFREE, 12'd4080},
      '{ACT_FREE,  13'd0,    13'd0,    12'd15,  1'b1, 12'd0,  ST_BADFREE, 12'd4080},
      '{ACT_ALLOC, 13'd16,   13'd0,    12'd0,   1'b1, 12'd16, ST_OK,      12'd4048},
      '{ACT_ALLOC, 13'd100,  13'd0,    12'd0,   1'b0, 12'd0,  ST_OK,      12'd0},
      '{ACT_ALLOC, 13'd32,   13'd0,    12'd0,   1'b0, 12'd0,  ST_OK,      12'd0},
      '{ACT_FREE,  13'd0,    13'd0,    12'd48,  1'b0, 12'd0,  ST_OK,      12'd0},
      '{ACT_FREE,  13'd0,    13'd0,    12'd16,  1'b0, 12'd0,  ST_OK,      12'd0},
      '{ACT_FREE,  13'd0,    13'd0,    12'd164, 1'b0, 12'd0,  ST_OK,      12'd0},
      '{ACT_FREE,  13'd0,    13'd0,    12'd16,  1'b1, 12'd0,  ST_BADFREE, 12'd4080},
      '{ACT_ALLOC, 13'd4080, 13'd0,    12'd0,   1'b1, 12'd16, ST_OK,      12'd0},
      '{ACT_ALLOC, 13'd1,    13'd0,    12'd0,   1'b1, 12'd0,  ST_NOFREE,  12'd0},
      '{ACT_FREE,  13'd0,    13'd0,    12'd16,  1'b1, 12'd0,  ST_OK,      12'd4080}
    };

    // Shadow pool after reset
    for (int i = 0; i < POOL; i++) begin
      pool_mem[i] = '0;
      pool_seen[i] = 1'b0;
    end
    hdr_write(HB, B_PREV, 0);
    hdr_write(HB, B_NEXT, 0);
    hdr_write(HB, B_USED, 0);
    hdr_write(HB, B_SIZE, POOL - HB);
    free_cnt = 13'(POOL - HB);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table
    foreach (rows[i]) begin
      offer(rows[i].act, rows[i].len, rows[i].res, rows[i].off, got);
      if (rows[i].typed)
        pending_q.push_back('{rows[i].e_region, rows[i].e_st, rows[i].e_free});
      else
        pending_q.push_back(got);
    end

    // Random traffic, mostly well-formed allocate/free with some noise
    for (int n = 0; n < N_RANDOM; n++) begin
      quiet = (n >= 400 && n < 650);
      act = ACT_ALLOC;
      len = '0;
      res = '0;
      off = '0;
      k = $urandom_range(99);
      if (k < 52 || live_q.size() == 0) begin
        k = $urandom_range(99);
        if (k < 80) len = 13'($urandom_range(256, 1));
        else if (k < 92) len = 13'($urandom_range(4096, 257));
        else if (k < 97) len = 13'($urandom_range(8191, 4097));
        else len = '0;
        k = $urandom_range(99);
        if (k < 70) res = '0;
        else if (k < 90) res = 13'($urandom_range(600));
        else res = 13'($urandom_range(8191));
        off = 12'($urandom_range(4095));
      end else begin
        act = ACT_FREE;
        len = 13'($urandom_range(8191));
        res = 13'($urandom_range(8191));
        k = $urandom_range(99);
        if (k < 88) off = 12'(live_q[$urandom_range(live_q.size() - 1)]);
        else if (k < 92) off = 12'($urandom_range(15));
        else if (k < 96 && dead_q.size() != 0)
          off = 12'(dead_q[$urandom_range(dead_q.size() - 1)]);
        else begin
          off = 12'($urandom_range(4095));
          if (!header_known(32'(off))) off = 12'(live_q[$urandom_range(live_q.size() - 1)]);
        end
      end
      offer(act, len, res, off, got);
      pending_q.push_back(got);
    end
    quiet = 1'b0;
    @(negedge clk);
    in_valid = 1'b0;

    // Drain
    while (pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("tb_first_fit_pool_allocator_unit OK");
    else $display("tb_first_fit_pool_allocator_unit NOT OK");
    $finish;
  end

endmodule
